// ===== hw/rtl/beam_matrix_note_trigger_core_assert.svh =====
// Assertion macros shared by the beam matrix note trigger modules.
`ifndef BEAM_MATRIX_NOTE_TRIGGER_CORE_ASSERT_SVH
`define BEAM_MATRIX_NOTE_TRIGGER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset (uses the module's clk and rst_n).
`define BMNT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMNT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bmnt_pkg.sv =====
// Types, constants and the note table for the beam matrix note trigger.
package bmnt_pkg;

    localparam int BEAMS_PER_AXIS = 8;
    localparam int BEAM_IDX_W     = $clog2(BEAMS_PER_AXIS);
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FLIPPED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACT_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHAN   = 2'd2;

    localparam logic [15:0] MAX_ACT_MS_RESET = 16'd100;

    localparam logic [7:0] NO_NOTE   = 8'hFF;
    localparam logic [6:0] VEL_MAX   = 7'd127;
    localparam logic [6:0] VEL_MIN   = 7'd1;
    localparam logic [6:0] VEL_SLOPE = 7'd126;

    // Indexed [row][column]; row is the Y beam in normal orientation.
    localparam logic [7:0] NOTE_TABLE [BEAMS_PER_AXIS][BEAMS_PER_AXIS] = '{
        '{NO_NOTE, 8'd72, 8'd73, 8'd81, 8'd82, 8'd90, NO_NOTE, 8'd98},
        '{8'd60, 8'd61, 8'd74, 8'd75, 8'd83, NO_NOTE, 8'd91, 8'd92},
        '{8'd54, 8'd62, 8'd63, 8'd76, NO_NOTE, 8'd84, 8'd85, 8'd93},
        '{8'd55, 8'd56, 8'd64, NO_NOTE, 8'd77, 8'd78, 8'd86, 8'd87},
        '{8'd49, 8'd57, NO_NOTE, 8'd65, 8'd66, 8'd79, 8'd80, 8'd88},
        '{8'd50, NO_NOTE, 8'd58, 8'd59, 8'd67, 8'd68, 8'd81, 8'd82},
        '{NO_NOTE, 8'd51, 8'd52, 8'd60, 8'd61, 8'd69, 8'd70, 8'd83},
        '{8'd44, 8'd45, 8'd53, 8'd54, 8'd62, 8'd63, 8'd71, NO_NOTE}
    };

    typedef struct packed {
        logic [7:0]  x_beams;
        logic [7:0]  y_beams;
        logic [31:0] now_ms;
    } scan_t;

    typedef struct packed {
        logic       is_note_on;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] channel;
        logic       last_event;
    } evt_t;

    typedef struct packed {
        logic                  valid;
        logic [BEAM_IDX_W-1:0] idx;
    } axis_pos_t;

    // Work handed from the front to the back.
    typedef struct packed {
        logic        off_valid;
        logic [6:0]  off_note;
        logic        on_valid;
        logic [6:0]  on_note;
        logic [31:0] delay;
    } cmd_t;

    function automatic logic [7:0] table_note(input logic flip,
                                              input logic [BEAM_IDX_W-1:0] x,
                                              input logic [BEAM_IDX_W-1:0] y);
        logic [7:0] n;
        if (flip)
        begin
            n = NOTE_TABLE[~x][~y];
        end
        else
        begin
            n = NOTE_TABLE[y][x];
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/bmnt_front.sv =====
// Scan front end: axis tracking, held pair state and command generation.
module bmnt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            flipped,
    input  logic            scan_valid,
    output logic            scan_stall,
    input  bmnt_pkg::scan_t scan_item,
    input  logic            q_full,
    output logic            push,
    output bmnt_pkg::cmd_t  push_data
);
    import bmnt_pkg::*;

    axis_pos_t   raw_x_reg, raw_y_reg, held_x_reg, held_y_reg;
    axis_pos_t   raw_x_next, raw_y_next, held_x_next, held_y_next;
    logic        held_active_reg, held_active_next;
    logic [6:0]  held_note_reg, held_note_next;
    logic [31:0] single_time_reg, single_time_next;

    axis_pos_t   cx, cy;
    logic        accept, raw_same, held_same, one_axis, active, fire;
    logic [7:0]  grid_note;

    function automatic axis_pos_t scan_axis(input logic [BEAMS_PER_AXIS-1:0] beams,
                                            input axis_pos_t held);
        axis_pos_t r;
        r.valid = 1'b0;
        r.idx   = '0;
        if (held.valid && beams[held.idx])
        begin
            r = held;
        end
        else if ($onehot(beams))
        begin
            r.valid = 1'b1;
            for (int i = 0; i < BEAMS_PER_AXIS; i++)
            begin
                if (beams[i])
                begin
                    r.idx = BEAM_IDX_W'(i);
                end
            end
        end
        return r;
    endfunction

    function automatic logic same_pos(input axis_pos_t a, input axis_pos_t b);
        return (a.valid == b.valid) && (!a.valid || a.idx == b.idx);
    endfunction

    assign scan_stall = q_full;
    assign accept     = scan_valid && !q_full;

    always_comb
    begin
        cx        = scan_axis(scan_item.x_beams, held_x_reg);
        cy        = scan_axis(scan_item.y_beams, held_y_reg);
        raw_same  = same_pos(cx, raw_x_reg) && same_pos(cy, raw_y_reg);
        held_same = same_pos(cx, held_x_reg) && same_pos(cy, held_y_reg);
        one_axis  = cx.valid != cy.valid;
        grid_note = table_note(flipped, cx.idx, cy.idx);
        active    = cx.valid && cy.valid && (grid_note != NO_NOTE);
        fire      = accept && !raw_same && !one_axis && !held_same;

        push                = fire && (held_active_reg || active);
        push_data.off_valid = held_active_reg;
        push_data.off_note  = held_note_reg;
        push_data.on_valid  = active;
        push_data.on_note   = grid_note[6:0];
        push_data.delay     = scan_item.now_ms - single_time_reg;

        raw_x_next       = raw_x_reg;
        raw_y_next       = raw_y_reg;
        held_x_next      = held_x_reg;
        held_y_next      = held_y_reg;
        held_active_next = held_active_reg;
        held_note_next   = held_note_reg;
        single_time_next = single_time_reg;

        if (accept && !raw_same)
        begin
            raw_x_next = cx;
            raw_y_next = cy;
            // record when only one axis is interrupted
            if (one_axis)
            begin
                single_time_next = scan_item.now_ms;
            end
        end
        if (fire)
        begin
            held_x_next      = cx;
            held_y_next      = cy;
            held_active_next = active;
            if (active)
            begin
                held_note_next = grid_note[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_x_reg       <= '0;
            raw_y_reg       <= '0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            held_active_reg <= 1'b0;
            held_note_reg   <= '0;
            single_time_reg <= '0;
        end
        else
        begin
            raw_x_reg       <= raw_x_next;
            raw_y_reg       <= raw_y_next;
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
            held_active_reg <= held_active_next;
            held_note_reg   <= held_note_next;
            single_time_reg <= single_time_next;
        end
    end

endmodule

// ===== hw/rtl/bmnt_queue.sv =====
// Small command queue between the front end and the event back end.
`include "beam_matrix_note_trigger_core_assert.svh"

module bmnt_queue #(
    parameter int DEPTH = bmnt_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bmnt_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output bmnt_pkg::cmd_t pop_data,
    output logic           empty
);
    import bmnt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BMNT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overrun")
    `BMNT_ASSERT_IMP(a_no_push_full, full, !push, "push into full queue")
    `BMNT_ASSERT_IMP(a_no_pop_empty, empty, !pop, "pop from empty queue")

endmodule

// ===== hw/rtl/bmnt_back.sv =====
// Event back end: velocity divide and note-off / note-on output register.
`include "beam_matrix_note_trigger_core_assert.svh"

module bmnt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    max_act_ms,
    input  logic [3:0]     midi_channel,
    input  logic           q_empty,
    input  bmnt_pkg::cmd_t q_data,
    output logic           pop,
    output logic           evt_valid,
    input  logic           evt_stall,
    output bmnt_pkg::evt_t evt_item
);
    import bmnt_pkg::*;

    // delay (at most max, 16 bits) times the 7-bit slope
    localparam int DVD_W = 16 + 7;
    localparam int CNT_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OFF,
        S_ON
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [15:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [6:0]       vel_reg, vel_next;
    logic             out_valid_reg, out_valid_next;
    evt_t             out_item_reg, out_item_next;

    logic             can_load;
    logic [16:0]      rem_shift;
    logic             ge;
    state_t           after_vel;

    assign can_load  = !out_valid_reg || !evt_stall;
    assign after_vel = cmd_reg.off_valid ? S_OFF : S_ON;
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge        = rem_shift >= {1'b0, max_act_ms};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        vel_next       = vel_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;

        if (out_valid_reg && !evt_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = q_data;
                    state_next = q_data.on_valid ? S_MUL : S_OFF;
                end
            end
            S_MUL:
            begin
                if (max_act_ms == '0)
                begin
                    vel_next   = (cmd_reg.delay == '0) ? VEL_MAX : VEL_MIN;
                    state_next = after_vel;
                end
                else if (cmd_reg.delay > {16'd0, max_act_ms})
                begin
                    vel_next   = VEL_MIN;
                    state_next = after_vel;
                end
                else
                begin
                    dvd_next   = DVD_W'(cmd_reg.delay[15:0]) * DVD_W'(VEL_SLOPE);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle, restoring
                rem_next = ge ? 16'(rem_shift - {1'b0, max_act_ms}) : rem_shift[15:0];
                dvd_next = {dvd_reg[DVD_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    vel_next   = VEL_MAX - dvd_next[6:0];
                    state_next = after_vel;
                end
            end
            S_OFF:
            begin
                if (can_load)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.is_note_on = 1'b0;
                    out_item_next.note       = cmd_reg.off_note;
                    out_item_next.velocity   = '0;
                    out_item_next.channel    = midi_channel;
                    out_item_next.last_event = !cmd_reg.on_valid;
                    state_next               = cmd_reg.on_valid ? S_ON : S_IDLE;
                end
            end
            S_ON:
            begin
                if (can_load)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.is_note_on = 1'b1;
                    out_item_next.note       = cmd_reg.on_note;
                    out_item_next.velocity   = vel_reg;
                    out_item_next.channel    = midi_channel;
                    out_item_next.last_event = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            vel_reg       <= '0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            dvd_reg       <= dvd_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            vel_reg       <= vel_next;
            out_item_reg  <= out_item_next;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt_item  = out_item_reg;

    `BMNT_ASSERT_IMP(a_on_vel, out_valid_reg && out_item_reg.is_note_on,
                     out_item_reg.velocity != '0, "note-on with zero velocity")
    `BMNT_ASSERT_IMP(a_off_vel, out_valid_reg && !out_item_reg.is_note_on,
                     out_item_reg.velocity == '0, "note-off with nonzero velocity")
    `BMNT_ASSERT_IMP(a_div_nonzero, state_reg == S_DIV, max_act_ms != '0, "divide by zero")

endmodule

// ===== hw/rtl/beam_matrix_note_trigger_core.sv =====
// Beam matrix note trigger top level: configuration registers and front/queue/back.
//
// Each accepted scan is classified combinationally by the front end and, if it
// changes the held note, turned into a command in a two-entry queue. The back
// end emits the note-off and/or note-on items through an output register. A
// scan that yields only a note-off takes a pop, then an emit. One with a note-on
// takes a pop, a multiply, a restoring divide of delay*126 by max_activation_ms
// and then an emit per item; a delay beyond the maximum or a zero maximum skips
// the divide. Output stalls can hold the emits. Scans that produce no item are
// taken every cycle while the queue has room.
// Write configuration only while idle.
module beam_matrix_note_trigger_core #(
    parameter int QUEUE_DEPTH = bmnt_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bmnt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmnt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             scan_valid,
    output logic                             scan_stall,
    input  bmnt_pkg::scan_t                  scan_item,
    output logic                             evt_valid,
    input  logic                             evt_stall,
    output bmnt_pkg::evt_t                   evt_item
);
    import bmnt_pkg::*;

    logic        flipped_reg;
    logic [15:0] max_act_reg;
    logic [3:0]  channel_reg;

    logic        push, pop, q_full, q_empty;
    cmd_t        push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flipped_reg <= 1'b0;
            max_act_reg <= MAX_ACT_MS_RESET;
            channel_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLIPPED:    flipped_reg <= cfg_data[0];
                CFG_MAX_ACT_MS: max_act_reg <= cfg_data[15:0];
                CFG_MIDI_CHAN:  channel_reg <= cfg_data[3:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    bmnt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .flipped    (flipped_reg),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_item  (scan_item),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    bmnt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    bmnt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_act_ms   (max_act_reg),
        .midi_channel (channel_reg),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .pop          (pop),
        .evt_valid    (evt_valid),
        .evt_stall    (evt_stall),
        .evt_item     (evt_item)
    );

endmodule

// ===== sim/bmnt_event_checker.sv =====
// Event checker for the beam matrix note trigger: mirrors the registers, predicts, compares.
module bmnt_event_checker
    import bmnt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  scan_valid,
    input  logic                  scan_stall,
    input  scan_t                 scan_item,
    input  logic                  evt_valid,
    input  logic                  evt_stall,
    input  evt_t                  evt_item,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         REPORT_LIMIT = 10;
    localparam logic [7:0] EMPTY_CELL   = 8'hFF;
    localparam logic [6:0] VEL_LOUDEST  = 7'd127;
    localparam logic [6:0] VEL_SOFTEST  = 7'd1;
    localparam logic [6:0] VEL_RANGE    = 7'd126;

    // Row is the Y beam, column the X beam, in normal orientation.
    localparam logic [7:0] CELL_NOTE [8][8] = '{
        '{EMPTY_CELL, 8'd72, 8'd73, 8'd81, 8'd82, 8'd90, EMPTY_CELL, 8'd98},
        '{8'd60, 8'd61, 8'd74, 8'd75, 8'd83, EMPTY_CELL, 8'd91, 8'd92},
        '{8'd54, 8'd62, 8'd63, 8'd76, EMPTY_CELL, 8'd84, 8'd85, 8'd93},
        '{8'd55, 8'd56, 8'd64, EMPTY_CELL, 8'd77, 8'd78, 8'd86, 8'd87},
        '{8'd49, 8'd57, EMPTY_CELL, 8'd65, 8'd66, 8'd79, 8'd80, 8'd88},
        '{8'd50, EMPTY_CELL, 8'd58, 8'd59, 8'd67, 8'd68, 8'd81, 8'd82},
        '{EMPTY_CELL, 8'd51, 8'd52, 8'd60, 8'd61, 8'd69, 8'd70, 8'd83},
        '{8'd44, 8'd45, 8'd53, 8'd54, 8'd62, 8'd63, 8'd71, EMPTY_CELL}
    };

    logic        flip_cfg;
    logic [15:0] max_ms_cfg;
    logic [3:0]  chan_cfg;

    axis_pos_t   last_x;
    axis_pos_t   last_y;
    axis_pos_t   hold_x;
    axis_pos_t   hold_y;
    logic        note_sounding;
    logic [6:0]  sounding_note;
    logic [31:0] one_axis_ms;

    evt_t        expected_events [$];
    int          fail_count;
    int          shown;

    function automatic axis_pos_t pick_axis(logic [7:0] beams, axis_pos_t held);
        axis_pos_t p;
        p = '0;
        // Keep the held beam while it is still interrupted.
        if (held.valid && beams[held.idx])
        begin
            return held;
        end
        for (int i = 0; i < 8; i++)
        begin
            if (beams[i])
            begin
                p.idx = i[2:0];
            end
        end
        p.valid = ($countones(beams) == 1);
        if (!p.valid)
        begin
            p.idx = '0;
        end
        return p;
    endfunction

    function automatic bit same_axis(axis_pos_t a, axis_pos_t b);
        return (a.valid == b.valid) && (!a.valid || a.idx == b.idx);
    endfunction

    function automatic void predict_scan(scan_t s);
        axis_pos_t   cx;
        axis_pos_t   cy;
        logic [7:0]  grid_note;
        logic [31:0] dt;
        logic [63:0] scaled;
        logic [6:0]  vel;
        logic        strike;
        evt_t        e;
        cx = pick_axis(s.x_beams, hold_x);
        cy = pick_axis(s.y_beams, hold_y);
        if (same_axis(cx, last_x) && same_axis(cy, last_y))
        begin
            return;
        end
        last_x = cx;
        last_y = cy;
        if (cx.valid != cy.valid)
        begin
            one_axis_ms = s.now_ms;
            return;
        end
        if (same_axis(cx, hold_x) && same_axis(cy, hold_y))
        begin
            return;
        end
        strike    = 1'b0;
        vel       = '0;
        grid_note = EMPTY_CELL;
        if (cx.valid)
        begin
            grid_note = flip_cfg ? CELL_NOTE[3'd7 - cx.idx][3'd7 - cy.idx]
                                 : CELL_NOTE[cy.idx][cx.idx];
            strike = (grid_note != EMPTY_CELL);
        end
        if (strike)
        begin
            dt = s.now_ms - one_axis_ms;
            if (max_ms_cfg == 16'd0)
            begin
                vel = (dt == 32'd0) ? VEL_LOUDEST : VEL_SOFTEST;
            end
            else if (dt > {16'd0, max_ms_cfg})
            begin
                vel = VEL_SOFTEST;
            end
            else
            begin
                scaled = ({32'd0, dt} * {57'd0, VEL_RANGE}) / {48'd0, max_ms_cfg};
                vel = 7'({57'd0, VEL_LOUDEST} - scaled);
            end
        end
        if (note_sounding)
        begin
            e.is_note_on = 1'b0;
            e.note       = sounding_note;
            e.velocity   = '0;
            e.channel    = chan_cfg;
            e.last_event = !strike;
            expected_events.push_back(e);
        end
        if (strike)
        begin
            e.is_note_on = 1'b1;
            e.note       = grid_note[6:0];
            e.velocity   = vel;
            e.channel    = chan_cfg;
            e.last_event = 1'b1;
            expected_events.push_back(e);
            sounding_note = grid_note[6:0];
        end
        hold_x        = cx;
        hold_y        = cy;
        note_sounding = strike;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        evt_t want;
        if (!rst_n)
        begin
            flip_cfg      = 1'b0;
            max_ms_cfg    = 16'd100;
            chan_cfg      = '0;
            last_x        = '0;
            last_y        = '0;
            hold_x        = '0;
            hold_y        = '0;
            note_sounding = 1'b0;
            sounding_note = '0;
            one_axis_ms   = '0;
            fail_count    = 0;
            shown         = 0;
            expected_events.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // Compare first: an item leaving now never belongs to a scan taken now.
            if (evt_valid && !evt_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    if (shown < REPORT_LIMIT)
                    begin
                        shown++;
                        $display("unexpected event: on=%0d note=%0d vel=%0d ch=%0d last=%0d",
                                 evt_item.is_note_on, evt_item.note, evt_item.velocity,
                                 evt_item.channel, evt_item.last_event);
                    end
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (evt_item.is_note_on !== want.is_note_on || evt_item.note !== want.note
                        || evt_item.velocity !== want.velocity
                        || evt_item.channel !== want.channel
                        || evt_item.last_event !== want.last_event)
                    begin
                        fail_count++;
                        if (shown < REPORT_LIMIT)
                        begin
                            shown++;
                            $display("event mismatch: expected on=%0d note=%0d vel=%0d",
                                     want.is_note_on, want.note, want.velocity,
                                     " ch=%0d last=%0d", want.channel, want.last_event);
                            $display("                got      on=%0d note=%0d vel=%0d",
                                     evt_item.is_note_on, evt_item.note, evt_item.velocity,
                                     " ch=%0d last=%0d", evt_item.channel,
                                     evt_item.last_event);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FLIPPED:    flip_cfg   = cfg_data[0];
                    CFG_MAX_ACT_MS: max_ms_cfg = cfg_data[15:0];
                    CFG_MIDI_CHAN:  chan_cfg   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (scan_valid && !scan_stall)
            begin
                predict_scan(scan_item);
            end
            errors  <= fail_count;
            pending <= expected_events.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the beam matrix note trigger: clock, reset, scan stimulus and verdict.
module tb_top
    import bmnt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int BLOCK_ITEMS    = 400;
    localparam int PHASE_ITEMS    = 100;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  scan_valid = 1'b0;
    logic                  scan_stall;
    scan_t                 scan_item  = '0;
    logic                  evt_valid;
    logic                  evt_stall  = 1'b0;
    evt_t                  evt_item;

    int          errors;
    int          pending;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          max_ms_now = 100;
    int          items_sent = 0;
    int          watchdog   = 0;
    logic [31:0] clock_ms;

    beam_matrix_note_trigger_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_item  (scan_item),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_item   (evt_item)
    );

    bmnt_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_item  (scan_item),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_item   (evt_item),
        .errors     (errors),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_stall <= 1'b0;
        end
        else
        begin
            evt_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((scan_valid && !scan_stall) || (evt_valid && !evt_stall))
        begin
            watchdog <= 0;
        end
        else
        begin
            watchdog <= watchdog + 1;
        end
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_beams(input logic [7:0] xb, input logic [7:0] yb, input logic [31:0] t);
        scan_t s;
        s.x_beams = xb;
        s.y_beams = yb;
        s.now_ms  = t;
        while ($urandom_range(99) < idle_pct)
        begin
            scan_valid <= 1'b0;
            @(posedge clk);
        end
        scan_item  <= s;
        scan_valid <= 1'b1;
        @(posedge clk);
        while (scan_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Drop valid, wait for every expected item, then let the back end run dry.
    task automatic settle();
        scan_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic flip, input logic [15:0] max_ms, input logic [3:0] chan);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FLIPPED;
        cfg_data  <= {15'd0, flip};
        @(posedge clk);
        cfg_index <= CFG_MAX_ACT_MS;
        cfg_data  <= max_ms;
        @(posedge clk);
        cfg_index <= CFG_MIDI_CHAN;
        cfg_data  <= {12'd0, chan};
        @(posedge clk);
        cfg_we     <= 1'b0;
        max_ms_now = max_ms;
    endtask

    // One hand through the grid: one axis, both axes, hold with extra beams, then leave or move.
    task automatic play_gesture();
        logic [2:0] xi;
        logic [2:0] yi;
        logic [7:0] xo;
        logic [7:0] yo;
        bit         x_first;
        int         hold;
        xi      = 3'($urandom_range(7));
        yi      = 3'($urandom_range(7));
        xo      = 8'd1 << xi;
        yo      = 8'd1 << yi;
        x_first = 1'($urandom_range(1));
        clock_ms += $urandom_range(0, 50);
        send_beams(x_first ? xo : 8'h00, x_first ? 8'h00 : yo, clock_ms);
        clock_ms += $urandom_range(0, max_ms_now + max_ms_now / 2 + 2);
        send_beams(xo, yo, clock_ms);
        hold = $urandom_range(0, 3);
        repeat (hold)
        begin
            clock_ms += $urandom_range(0, 20);
            send_beams(xo | ($urandom_range(1) ? 8'($urandom) : 8'h00),
                       yo | ($urandom_range(1) ? 8'($urandom) : 8'h00), clock_ms);
        end
        clock_ms += $urandom_range(0, max_ms_now + 2);
        case ($urandom_range(3))
            0: send_beams(8'h00, 8'h00, clock_ms);
            1: send_beams(8'd1 << $urandom_range(7), yo, clock_ms);
            2: send_beams(xo, 8'd1 << $urandom_range(7), clock_ms);
            default: send_beams(xo, 8'h00, clock_ms);
        endcase
    endtask

    initial
    begin
        int base;
        clock_ms = $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans at reset settings.
        send_beams(8'h00, 8'h00, 32'd0);
        send_beams(8'h01, 8'h00, 32'd10);
        send_beams(8'h01, 8'h01, 32'd10);          // empty cell, nothing sounding
        send_beams(8'h02, 8'h00, 32'd20);
        send_beams(8'h02, 8'h02, 32'd20);          // zero delay, loudest
        send_beams(8'h03, 8'h02, 32'd500);         // held beam among several
        send_beams(8'h05, 8'h02, 32'd600);         // several beams, none held
        send_beams(8'h04, 8'h02, 32'd650);         // note-off then note-on
        send_beams(8'h00, 8'h00, 32'd700);
        send_beams(8'h00, 8'h08, 32'hFFFF_FFF0);
        send_beams(8'h10, 8'h08, 32'h0000_0010);   // delay across the wrap
        send_beams(8'hFF, 8'hFF, 32'h0000_0020);
        send_beams(8'h80, 8'h08, 32'h0000_0074);   // delay beyond the maximum
        send_beams(8'h80, 8'h80, 32'd1000);        // empty cell with a note sounding
        send_beams(8'h00, 8'h80, 32'd2000);
        send_beams(8'h40, 8'h80, 32'hFFFF_FFFF);   // delay far beyond the maximum
        send_beams(8'h40, 8'h80, 32'hFFFF_FFFF);
        settle();

        // Zero maximum: full velocity only without delay.
        program_regs(1'b0, 16'd0, 4'd9);
        send_beams(8'h00, 8'h00, 32'd0);
        send_beams(8'h01, 8'h00, 32'd300);
        send_beams(8'h01, 8'h04, 32'd300);
        send_beams(8'h02, 8'h00, 32'd400);
        send_beams(8'h02, 8'h04, 32'd401);

        base = items_sent;
        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++)
        begin
            idle_pct  = 0;
            stall_pct = 0;
            settle();
            case (blk)
                0: program_regs(1'b1, 16'd1, 4'd15);
                1: program_regs(1'b0, 16'hFFFF, 4'd0);
                2: program_regs(1'b1, 16'd100, 4'($urandom));
                default: program_regs(1'($urandom_range(1)), 16'($urandom_range(1, 400)),
                                      4'($urandom));
            endcase
            while (items_sent - base < (blk + 1) * BLOCK_ITEMS)
            begin
                case (((items_sent - base) / PHASE_ITEMS) % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 66; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 66; end
                    default: begin idle_pct = 12; stall_pct = 12; end
                endcase
                if ($urandom_range(99) < 5)
                begin
                    clock_ms = $urandom;
                end
                if ($urandom_range(99) < 20)
                begin
                    clock_ms += $urandom_range(0, 200);
                    send_beams(8'($urandom), 8'($urandom), clock_ms);
                end
                else
                begin
                    play_gesture();
                end
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        settle();
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bmnt_pkg.sv
hw/rtl/bmnt_front.sv
hw/rtl/bmnt_queue.sv
hw/rtl/bmnt_back.sv
hw/rtl/beam_matrix_note_trigger_core.sv
sim/bmnt_event_checker.sv
sim/tb_top.sv
